[rtl/lbp3_pkg.sv]
// Shared types and constants for the 3x3 local binary pattern block.
package lbp3_pkg;

  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 1024;

  localparam int unsigned PixW  = 8;
  localparam int unsigned DimW  = 11;
  localparam int unsigned PosW  = 10;
  localparam int unsigned AddrW = $clog2(MaxWidth);
  localparam int unsigned CfgW  = 1;

  localparam logic [DimW-1:0] DimMin         = DimW'(3);
  localparam logic [DimW-1:0] WidthMax       = DimW'(MaxWidth);
  localparam logic [DimW-1:0] HeightMax      = DimW'(MaxHeight);
  localparam logic [DimW-1:0] WidthResetVal  = DimW'(640);
  localparam logic [DimW-1:0] HeightResetVal = DimW'(480);

  // Configuration register indexes
  localparam logic [CfgW-1:0] RegImageWidth  = CfgW'(0);
  localparam logic [CfgW-1:0] RegImageHeight = CfgW'(1);

  typedef logic [PixW-1:0] pix_t;

  // Window indexed [row][col]: row 0 top, col 0 left
  typedef pix_t [2:0][2:0] win_t;

endpackage

[rtl/lbp3_code.sv]
// Neighbor compare against the window center, producing the 8-bit pattern code.
module lbp3_code (
  input  lbp3_pkg::win_t            window_i,
  output logic [lbp3_pkg::PixW-1:0] pattern_o
);

  lbp3_pkg::pix_t ctr;

  assign ctr = window_i[1][1];

  // Bit 7 top-left, then clockwise around to bit 0 left
  always_comb begin
    pattern_o[7] = window_i[0][0] > ctr;
    pattern_o[6] = window_i[0][1] > ctr;
    pattern_o[5] = window_i[0][2] > ctr;
    pattern_o[4] = window_i[1][2] > ctr;
    pattern_o[3] = window_i[2][2] > ctr;
    pattern_o[2] = window_i[2][1] > ctr;
    pattern_o[1] = window_i[2][0] > ctr;
    pattern_o[0] = window_i[1][0] > ctr;
  end

endmodule

[rtl/local_binary_pattern_3x3.sv]
// Top level: 3x3 local binary pattern over a raster-order 8-bit pixel stream.
// Each accepted pixel request passes stage 1, then the output register, to its result.
// Throughput: one pixel per cycle unless results stall, set by the single
//   read-modify-write of the line store memory (one read, one write each cycle).
// Reset: position counters and window clear, image size returns to 640x480;
//   the line store memory is not cleared; stale entries only reach windows without a result.
module local_binary_pattern_3x3 (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [lbp3_pkg::CfgW-1:0]     cfg_idx_i,
  input  logic [lbp3_pkg::DimW-1:0]     cfg_data_i,
  // pixel request channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [lbp3_pkg::PixW-1:0]     pixel_i,
  input  logic                          frame_start_i,
  // pattern result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lbp3_pkg::PixW-1:0]     pattern_o,
  output logic [lbp3_pkg::PosW-1:0]     center_row_o,
  output logic [lbp3_pkg::PosW-1:0]     center_col_o,
  output logic                          frame_last_o
);

  localparam int unsigned DimW  = lbp3_pkg::DimW;
  localparam int unsigned PosW  = lbp3_pkg::PosW;
  localparam int unsigned PixW  = lbp3_pkg::PixW;
  localparam int unsigned AddrW = lbp3_pkg::AddrW;
  localparam int unsigned MemW  = 2 * PixW;

  // Clamp a programmed dimension to [3, maxv]
  function automatic logic [DimW-1:0] sat_dim(input logic [DimW-1:0] v,
                                              input logic [DimW-1:0] maxv);
    logic [DimW-1:0] res;
    res = v;
    if (v < lbp3_pkg::DimMin) res = lbp3_pkg::DimMin;
    else if (v > maxv)        res = maxv;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [DimW-1:0] width_q, height_q;
  logic [DimW-1:0] w_eff, h_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= lbp3_pkg::WidthResetVal;
      height_q <= lbp3_pkg::HeightResetVal;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lbp3_pkg::RegImageWidth:  width_q  <= cfg_data_i;
        lbp3_pkg::RegImageHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign w_eff = sat_dim(width_q, lbp3_pkg::WidthMax);
  assign h_eff = sat_dim(height_q, lbp3_pkg::HeightMax);

  // ---------------------------------------------------------------------------
  // Handshake control
  // ---------------------------------------------------------------------------
  logic in_fire, s1_fire;
  logic s1_valid_q, s1_emit_q, s1_last_q;

  // Stage 1 drains unless it carries a result and the output register is full and stalled
  assign s1_fire    = s1_valid_q && (!s1_emit_q || !out_valid_o || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------------------
  // Stage 0: position tracking and line store read
  // ---------------------------------------------------------------------------
  logic [PosW-1:0] row_q, col_q, row_d, col_d;
  logic [PosW-1:0] pos_row, pos_col;
  logic            pos_emit, pos_last;

  always_comb begin
    logic [DimW-1:0] r_ext, c_ext, r_nx, c_nx;
    // frame_start restarts at the origin; a shrunken size wraps the position
    r_ext = frame_start_i ? '0 : {1'b0, row_q};
    c_ext = frame_start_i ? '0 : {1'b0, col_q};
    if (c_ext >= w_eff) begin
      c_ext = '0;
      r_ext = r_ext + DimW'(1);
    end
    if (r_ext >= h_eff) r_ext = '0;
    pos_row = r_ext[PosW-1:0];
    pos_col = c_ext[PosW-1:0];

    pos_emit = (pos_row >= PosW'(2)) && (pos_col >= PosW'(2));
    pos_last = ({1'b0, pos_row} == h_eff - DimW'(1)) &&
               ({1'b0, pos_col} == w_eff - DimW'(1));

    // advance to the next raster position
    c_nx = {1'b0, pos_col} + DimW'(1);
    r_nx = {1'b0, pos_row} + DimW'(1);
    if (c_nx >= w_eff) begin
      col_d = '0;
      row_d = (r_nx >= h_eff) ? '0 : r_nx[PosW-1:0];
    end else begin
      col_d = c_nx[PosW-1:0];
      row_d = pos_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (in_fire) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Line store memory: each entry holds {row r-2, row r-1} for one column
  // ---------------------------------------------------------------------------
  logic [MemW-1:0]  mem_q [lbp3_pkg::MaxWidth];
  logic [MemW-1:0]  rd_q;
  logic [MemW-1:0]  wr_data;
  logic [MemW-1:0]  fwd_data_q;
  logic             fwd_q;
  logic [MemW-1:0]  rd_eff;
  logic [AddrW-1:0] s1_addr_q;

  always_ff @(posedge clk_i) begin
    if (s1_fire) mem_q[s1_addr_q] <= wr_data;
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) rd_q <= mem_q[pos_col[AddrW-1:0]];
  end

  // Same column read while stage 1 writes it back: forward the new entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (in_fire) begin
      fwd_q <= s1_fire && (s1_addr_q == pos_col[AddrW-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) fwd_data_q <= wr_data;
  end

  assign rd_eff = fwd_q ? fwd_data_q : rd_q;

  // ---------------------------------------------------------------------------
  // Stage 1: window shift, line store write-back, pattern compare
  // ---------------------------------------------------------------------------
  logic [PixW-1:0] s1_px_q;
  logic [PosW-1:0] s1_row_q, s1_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_emit_q  <= 1'b0;
      s1_last_q  <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
      s1_emit_q  <= in_valid_i && pos_emit;
      s1_last_q  <= pos_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_px_q   <= pixel_i;
      s1_row_q  <= pos_row;
      s1_col_q  <= pos_col;
      s1_addr_q <= pos_col[AddrW-1:0];
    end
  end

  // Move the older line up, drop the incoming pixel into the lower line
  assign wr_data = {rd_eff[PixW-1:0], s1_px_q};

  lbp3_pkg::win_t win_q, win_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_d[i][0] = win_q[i][1];
      win_d[i][1] = win_q[i][2];
    end
    win_d[0][2] = rd_eff[MemW-1:PixW];
    win_d[1][2] = rd_eff[PixW-1:0];
    win_d[2][2] = s1_px_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (s1_fire) begin
      win_q <= win_d;
    end
  end

  logic [PixW-1:0] code;

  lbp3_code u_code (
    .window_i  (win_d),
    .pattern_o (code)
  );

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_emit_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_emit_q) begin
      pattern_o    <= code;
      center_row_o <= s1_row_q - PosW'(1);
      center_col_o <= s1_col_q - PosW'(1);
      frame_last_o <= s1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[rtl/lbp3_checker.sv]
// Port-level checker for the local binary pattern block, bound to the top level.
module lbp3_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [lbp3_pkg::PixW-1:0] pattern_o,
  input logic [lbp3_pkg::PosW-1:0] center_row_o,
  input logic [lbp3_pkg::PosW-1:0] center_col_o,
  input logic                      frame_last_o
);

  // Hold a stalled result and its fields
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pattern_o) &&
      $stable(center_row_o) && $stable(center_col_o) && $stable(frame_last_o))
    else $error("stalled result changed");

  // A new result must follow an accepted pixel request
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without a pixel request two cycles earlier");

  // Centers on the top row or left column never produce a result
  a_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> center_row_o != '0 && center_col_o != '0)
    else $error("result for a border center");

  // Nothing comes out in the cycle after reset is released
  a_reset_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !out_valid_o)
    else $error("result right after reset");

endmodule

bind local_binary_pattern_3x3 lbp3_checker u_lbp3_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .pattern_o    (pattern_o),
  .center_row_o (center_row_o),
  .center_col_o (center_col_o),
  .frame_last_o (frame_last_o)
);
